### sv/iee_pkg.sv
// ---------------------------------------------------------------------------
// iee_pkg: shared definitions for the ising energy engine
// Field widths, operation codes and the command and status structs that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package iee_pkg;

   localparam int MAX_SITES_DEFAULT  = 64;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam int SITE_FIELD_BITS  = 6;
   localparam int COUNT_FIELD_BITS = 7;
   localparam int WEIGHT_BITS      = 16;
   localparam int SPIN_BITS        = 64;
   localparam int ENERGY_BITS      = 32;

   localparam logic [COUNT_FIELD_BITS-1:0] SITE_COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      MODE_WRITE_FIELD    = 2'd0,
      MODE_WRITE_COUPLING = 2'd1,
      MODE_TOTAL_ENERGY   = 2'd2,
      MODE_FLIP_DELTA     = 2'd3
   } mode_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic start;
      logic scan_step;
      logic load_out;
   } iee_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic write_op;
      logic bad;
      logic empty;
      logic scan_last;
   } iee_stat_type;

endpackage

### sv/iee_if.sv
// ---------------------------------------------------------------------------
// iee_if: channel interfaces of the ising energy engine
// Request, response and control register write channels, each with a
// valid/ready handshake.
// ---------------------------------------------------------------------------
interface iee_req_if
   import iee_pkg::*;
();
   logic                               valid;
   logic                               ready;
   mode_type                           mode;
   logic        [SITE_FIELD_BITS-1:0]  first_site;
   logic        [SITE_FIELD_BITS-1:0]  second_site;
   logic signed [WEIGHT_BITS-1:0]      weight;
   logic        [SPIN_BITS-1:0]        spins;
   logic                               new_spin;

   modport source (output valid, mode, first_site, second_site, weight, spins, new_spin,
                   input ready);
   modport sink   (input valid, mode, first_site, second_site, weight, spins, new_spin,
                   output ready);
endinterface

interface iee_rsp_if
   import iee_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [ENERGY_BITS-1:0] energy;
   logic                          status;

   modport source (output valid, energy, status, input ready);
   modport sink   (input valid, energy, status, output ready);
endinterface

interface iee_csr_if
   import iee_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [COUNT_FIELD_BITS-1:0] site_count;

   modport source (output valid, site_count, input ready);
   modport sink   (input valid, site_count, output ready);
endinterface

### sv/iee_ram.sv
// ---------------------------------------------------------------------------
// iee_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module iee_ram
   import iee_pkg::*;
#(
   parameter int WIDTH     = VALUE_BITS_DEFAULT,
   parameter int DEPTH     = MAX_SITES_DEFAULT,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/iee_datapath.sv
// ---------------------------------------------------------------------------
// iee_datapath: tables, index sequencing and accumulator
// Holds the field and coupling memories, the site count register, the
// scan counters that walk the packed triangle, the sum and the result.
// ---------------------------------------------------------------------------
module iee_datapath
   import iee_pkg::*;
#(
   parameter int MAX_SITES  = MAX_SITES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iee_cmd_type                   cmd,
   output iee_stat_type                  stat,
   input  mode_type                      req_mode,
   input  logic [SITE_FIELD_BITS-1:0]    req_first_site,
   input  logic [SITE_FIELD_BITS-1:0]    req_second_site,
   input  logic signed [WEIGHT_BITS-1:0] req_weight,
   input  logic [SPIN_BITS-1:0]          req_spins,
   input  logic                          req_new_spin,
   input  logic                          csr_valid,
   input  logic [COUNT_FIELD_BITS-1:0]   csr_site_count,
   output logic signed [ENERGY_BITS-1:0] rsp_energy,
   output logic                          rsp_status
);

   localparam int TRI_DEPTH = MAX_SITES * (MAX_SITES - 1) / 2;
   localparam int SITE_BITS = $clog2(MAX_SITES);
   localparam int CNT_BITS  = $clog2(MAX_SITES + 1);
   localparam int IDX_BITS  = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
   localparam int CLR_DEPTH = (TRI_DEPTH > MAX_SITES) ? TRI_DEPTH : MAX_SITES;
   localparam int CLR_BITS  = $clog2(CLR_DEPTH);
   localparam int PROD_BITS = 2 * CNT_BITS;
   localparam int SUM_BITS  = VALUE_BITS + $clog2(MAX_SITES + TRI_DEPTH + 1) + 1;
   localparam int ACC_BITS  = (SUM_BITS > ENERGY_BITS) ? SUM_BITS : ENERGY_BITS + 1;
   localparam int SAT_BITS  = (VALUE_BITS > WEIGHT_BITS) ? VALUE_BITS : WEIGHT_BITS;

   localparam logic signed [SAT_BITS-1:0] VAL_HI =
      SAT_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
   localparam logic signed [SAT_BITS-1:0] VAL_LO = ~VAL_HI;
   localparam logic signed [ACC_BITS-1:0] E_MAX =
      ACC_BITS'({1'b0, {(ENERGY_BITS - 1){1'b1}}});
   localparam logic signed [ACC_BITS-1:0] E_MIN = ~E_MAX;

   // registers
   logic [COUNT_FIELD_BITS-1:0]   site_count_ff, site_count_in;
   mode_type                      mode_ff, mode_in;
   logic [SITE_FIELD_BITS-1:0]    a_ff, a_in;
   logic [SITE_FIELD_BITS-1:0]    b_ff, b_in;
   logic signed [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [MAX_SITES-1:0]          spins_ff, spins_in;
   logic                          new_spin_ff, new_spin_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic                          fld_ff, fld_in;
   logic [SITE_BITS-1:0]          i_ff, i_in;
   logic [SITE_BITS-1:0]          j_ff, j_in;
   logic [IDX_BITS-1:0]           idx_ff, idx_in;
   logic                          add_ff, add_in;
   logic                          sel_field_ff, sel_field_in;
   logic [CLR_BITS-1:0]           clr_ff, clr_in;
   logic signed [ENERGY_BITS-1:0] energy_ff, energy_in;
   logic                          status_ff, status_in;

   // combinational
   logic [CNT_BITS-1:0]           n_eff;
   logic [COUNT_FIELD_BITS-1:0]   n_wide;
   logic [SITE_BITS-1:0]          a_site, b_site;
   logic [CNT_BITS-1:0]           a_cnt, b_cnt, i_cnt, j_cnt, i_next_cnt, j_next_cnt;
   logic [CNT_BITS-1:0]           last_i, incr_cnt;
   logic                          bad, occ_i, occ_j, negate;
   logic signed [SAT_BITS-1:0]    w_ext, w_sat;
   logic [PROD_BITS-1:0]          wr_idx_wide;
   logic signed [VALUE_BITS-1:0]  rd_value;
   logic signed [ACC_BITS-1:0]    result;

   // memory ports
   logic                          field_wr_en, pair_wr_en;
   logic [SITE_BITS-1:0]          field_wr_addr, field_rd_addr;
   logic [IDX_BITS-1:0]           pair_wr_addr, pair_rd_addr;
   logic [VALUE_BITS-1:0]         wr_data, field_rd_data, pair_rd_data;

   iee_ram #(
      .WIDTH     (VALUE_BITS),
      .DEPTH     (MAX_SITES),
      .ADDR_BITS (SITE_BITS)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (field_wr_en),
      .wr_addr (field_wr_addr),
      .wr_data (wr_data),
      .rd_addr (field_rd_addr),
      .rd_data (field_rd_data)
   );

   iee_ram #(
      .WIDTH     (VALUE_BITS),
      .DEPTH     (TRI_DEPTH),
      .ADDR_BITS (IDX_BITS)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (wr_data),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   always_comb begin
      n_eff = (site_count_ff > COUNT_FIELD_BITS'(MAX_SITES)) ?
              CNT_BITS'(MAX_SITES) : CNT_BITS'(site_count_ff);
      n_wide     = COUNT_FIELD_BITS'(n_eff);
      a_site     = a_ff[SITE_BITS-1:0];
      b_site     = b_ff[SITE_BITS-1:0];
      a_cnt      = CNT_BITS'(a_site);
      b_cnt      = CNT_BITS'(b_site);
      i_cnt      = CNT_BITS'(i_ff);
      j_cnt      = CNT_BITS'(j_ff);
      i_next_cnt = i_cnt + CNT_BITS'(1);
      j_next_cnt = j_cnt + CNT_BITS'(1);
      occ_i      = spins_ff[i_ff];
      occ_j      = spins_ff[j_ff];

      unique case (mode_ff)
         MODE_WRITE_FIELD:    bad = {1'b0, a_ff} >= n_wide;
         MODE_WRITE_COUPLING: bad = (a_ff >= b_ff) || ({1'b0, b_ff} >= n_wide);
         MODE_TOTAL_ENERGY:   bad = 1'b0;
         MODE_FLIP_DELTA:     bad = {1'b0, a_ff} >= n_wide;
         default:             bad = 1'b1;
      endcase

      // weight clamped to the stored value width
      w_ext = SAT_BITS'(w_ff);
      if (w_ext > VAL_HI) begin
         w_sat = VAL_HI;
      end else if (w_ext < VAL_LO) begin
         w_sat = VAL_LO;
      end else begin
         w_sat = w_ext;
      end
      wr_data = w_sat[VALUE_BITS-1:0];

      // packed triangle index of pair (a, b)
      wr_idx_wide = PROD_BITS'(n_eff - CNT_BITS'(1)) * PROD_BITS'(a_cnt)
                  - ((PROD_BITS'(a_cnt) * PROD_BITS'(a_cnt + CNT_BITS'(1))) >> 1)
                  + PROD_BITS'(b_cnt) - PROD_BITS'(1);

      // delta row walk: stride shrinks by one per row before the flipped site's row, then is one
      last_i = (a_cnt == n_eff - CNT_BITS'(1)) ? n_eff - CNT_BITS'(2)
                                               : n_eff - CNT_BITS'(1);
      if (i_next_cnt < a_cnt) begin
         incr_cnt = n_eff - CNT_BITS'(2) - i_cnt;
      end else if (i_next_cnt == a_cnt) begin
         incr_cnt = n_eff - a_cnt;
      end else begin
         incr_cnt = CNT_BITS'(1);
      end

      stat.clear_last = clr_ff == CLR_BITS'(CLR_DEPTH - 1);
      stat.write_op   = (mode_ff == MODE_WRITE_FIELD) || (mode_ff == MODE_WRITE_COUPLING);
      stat.bad        = bad;
      stat.empty      = (mode_ff == MODE_TOTAL_ENERGY) && (n_eff == '0);
      if (mode_ff == MODE_TOTAL_ENERGY) begin
         stat.scan_last = fld_ff && (i_next_cnt == n_eff);
      end else if (fld_ff) begin
         stat.scan_last = n_eff == CNT_BITS'(1);
      end else begin
         stat.scan_last = i_cnt == last_i;
      end

      field_rd_addr = (mode_ff == MODE_FLIP_DELTA) ? a_site : i_ff;
      pair_rd_addr  = idx_ff;

      field_wr_en   = 1'b0;
      pair_wr_en    = 1'b0;
      field_wr_addr = a_site;
      pair_wr_addr  = IDX_BITS'(wr_idx_wide);
      if (cmd.clear_step) begin
         field_wr_en   = {1'b0, clr_ff} < (CLR_BITS + 1)'(MAX_SITES);
         pair_wr_en    = {1'b0, clr_ff} < (CLR_BITS + 1)'(TRI_DEPTH);
         field_wr_addr = clr_ff[SITE_BITS-1:0];
         pair_wr_addr  = clr_ff[IDX_BITS-1:0];
         wr_data       = '0;
      end else if (cmd.start && !bad) begin
         field_wr_en = mode_ff == MODE_WRITE_FIELD;
         pair_wr_en  = mode_ff == MODE_WRITE_COUPLING;
      end

      rd_value = sel_field_ff ? field_rd_data : pair_rd_data;
      negate   = (mode_ff == MODE_TOTAL_ENERGY) ||
                 ((mode_ff == MODE_FLIP_DELTA) && new_spin_ff);
      result   = negate ? -acc_ff : acc_ff;

      site_count_in = csr_valid ? csr_site_count : site_count_ff;
      mode_in       = mode_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      spins_in      = spins_ff;
      new_spin_in   = new_spin_ff;
      acc_in        = acc_ff;
      fld_in        = fld_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      idx_in        = idx_ff;
      add_in        = 1'b0;
      sel_field_in  = sel_field_ff;
      clr_in        = cmd.clear_step ? clr_ff + CLR_BITS'(1) : clr_ff;
      energy_in     = energy_ff;
      status_in     = status_ff;

      if (cmd.load) begin
         mode_in     = req_mode;
         a_in        = req_first_site;
         b_in        = req_second_site;
         w_in        = req_weight;
         spins_in    = req_spins[MAX_SITES-1:0];
         new_spin_in = req_new_spin;
         acc_in      = '0;
      end else if (add_ff) begin
         acc_in = acc_ff + ACC_BITS'(rd_value);
      end

      if (cmd.start) begin
         fld_in = 1'b1;
         j_in   = '0;
         i_in   = '0;
         idx_in = '0;
         if (mode_ff == MODE_FLIP_DELTA) begin
            if (a_cnt == '0) begin
               i_in = SITE_BITS'(1);
            end else begin
               idx_in = IDX_BITS'(a_cnt - CNT_BITS'(1));
            end
         end
      end

      if (cmd.scan_step) begin
         if (mode_ff == MODE_TOTAL_ENERGY) begin
            if (fld_ff) begin
               add_in       = occ_i;
               sel_field_in = 1'b1;
               fld_in       = 1'b0;
               j_in         = SITE_BITS'(i_next_cnt);
            end else begin
               add_in       = occ_i & occ_j;
               sel_field_in = 1'b0;
               idx_in       = idx_ff + IDX_BITS'(1);
               if (j_next_cnt == n_eff) begin
                  fld_in = 1'b1;
                  i_in   = SITE_BITS'(i_next_cnt);
               end else begin
                  j_in = SITE_BITS'(j_next_cnt);
               end
            end
         end else begin
            if (fld_ff) begin
               add_in       = 1'b1;
               sel_field_in = 1'b1;
               fld_in       = 1'b0;
            end else begin
               add_in       = occ_i;
               sel_field_in = 1'b0;
               idx_in       = idx_ff + IDX_BITS'(incr_cnt);
               // step over the flipped site itself
               i_in = (i_next_cnt == a_cnt) ? SITE_BITS'(i_next_cnt + CNT_BITS'(1))
                                            : SITE_BITS'(i_next_cnt);
            end
         end
      end

      if (cmd.load_out) begin
         status_in = bad;
         if (result > E_MAX) begin
            energy_in = E_MAX[ENERGY_BITS-1:0];
         end else if (result < E_MIN) begin
            energy_in = E_MIN[ENERGY_BITS-1:0];
         end else begin
            energy_in = result[ENERGY_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= SITE_COUNT_RESET;
         clr_ff        <= '0;
         add_ff        <= 1'b0;
      end else begin
         site_count_ff <= site_count_in;
         clr_ff        <= clr_in;
         add_ff        <= add_in;
      end
      mode_ff      <= mode_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      w_ff         <= w_in;
      spins_ff     <= spins_in;
      new_spin_ff  <= new_spin_in;
      acc_ff       <= acc_in;
      fld_ff       <= fld_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      idx_ff       <= idx_in;
      sel_field_ff <= sel_field_in;
      energy_ff    <= energy_in;
      status_ff    <= status_in;
   end

   assign rsp_energy = energy_ff;
   assign rsp_status = status_ff;

endmodule

### sv/iee_ctrl.sv
// ---------------------------------------------------------------------------
// iee_ctrl: sequencing state machine
// Runs the clearing pass, accepts one transaction at a time, steps the
// datapath through its scan and hands the result to the output register.
// ---------------------------------------------------------------------------
module iee_ctrl
   import iee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output iee_cmd_type  cmd,
   input  iee_stat_type stat
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.start = 1'b1;
            if (stat.write_op || stat.bad || stat.empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read word lands in the accumulator
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/ising_energy_engine.sv
// ---------------------------------------------------------------------------
// ising_energy_engine: spin-system energy and single-flip delta engine
// Field and pair-coupling tables with total-energy and flip-delta queries.
// ---------------------------------------------------------------------------
// Usage
//   req_bus: one transaction per item; mode selects field write, coupling
//     write, total energy query or flip delta query.
//   rsp_bus: exactly one result per item, energy in Q24.8 and a status bit
//     that flags a bad site index or an unordered pair.
//   csr_bus: writes site_count; always ready, write only while idle.
// Sequencing of an item
//   writes and rejected queries: no scan, the result is registered after decode
//   flip delta query: one table word read per cycle
//   total energy query: every field and pair
//     word passes through the single read port of its memory
//   the next item is taken once the current one has reached the output
//   register, so a finished result may wait while the next one runs.
// Reset: both tables are swept to zero over the depth of the larger one,
//   req_bus.ready low meanwhile.
// A stalled rsp_bus holds its result; a second finished result waits
//   inside and req_bus.ready stays low until the first is taken.
// ---------------------------------------------------------------------------
module ising_energy_engine
   import iee_pkg::*;
#(
   parameter int MAX_SITES  = MAX_SITES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   iee_req_if.sink   req_bus,
   iee_rsp_if.source rsp_bus,
   iee_csr_if.sink   csr_bus
);

   iee_cmd_type  cmd;
   iee_stat_type stat;

   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   iee_datapath #(
      .MAX_SITES  (MAX_SITES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_bus.mode),
      .req_first_site  (req_bus.first_site),
      .req_second_site (req_bus.second_site),
      .req_weight      (req_bus.weight),
      .req_spins       (req_bus.spins),
      .req_new_spin    (req_bus.new_spin),
      .csr_valid       (csr_bus.valid),
      .csr_site_count  (csr_bus.site_count),
      .rsp_energy      (rsp_bus.energy),
      .rsp_status      (rsp_bus.status)
   );

   assign csr_bus.ready = 1'b1;

endmodule

### sv/iee_checker.sv
// ---------------------------------------------------------------------------
// iee_checker: port-level checks for the ising energy engine
// Watches the request and response channels over time.
// ---------------------------------------------------------------------------
module iee_checker
   import iee_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [ENERGY_BITS-1:0] rsp_energy,
   input logic                          rsp_status
);

   // transactions accepted whose result has not been taken yet
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // clearing pass keeps the input closed right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input open during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_energy) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an accepted request");

   assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two transactions in flight");

endmodule

bind ising_energy_engine iee_checker u_iee_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_energy (rsp_bus.energy),
   .rsp_status (rsp_bus.status)
);
